### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros, included by the top-level RTL file.
// Every macro samples on the rising edge of clock and is disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/rgbnpi_pkg.sv
// ---------------------------------------------------------------------------
// rgbnpi_pkg
// Types and constants shared by the nearest palette index search block.
// ---------------------------------------------------------------------------
`default_nettype none

package rgbnpi_pkg;

   // Item command codes.
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // A 5-bit color field expands as field*8 + 4.
   localparam logic [2:0] EXPAND_LOW_BITS = 3'b100;

   // Alpha byte of a packed palette word.
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   // Squared distance: three 16-bit squares summed.
   localparam int DIST_W = 18;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_wr;      // write a palette entry and answer the load
      logic query_start;  // capture the query color and clear the best match
      logic rd_en;        // read one palette entry into the search pipeline
      logic finish;       // the search is complete, answer the query
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pipe_busy;    // an entry is still in flight in the search pipeline
   } dp_status_type;

endpackage

`default_nettype wire

### hdl/rgb555_nearest_palette_index.sv
// ---------------------------------------------------------------------------
// rgb555_nearest_palette_index
// Palette store with a nearest-color search for 15-bit RGB colors.
// ---------------------------------------------------------------------------
// Usage:
//   An item is accepted at a rising clock edge where start is high and busy
//   is low. A load item (req_command = 0) writes req_red, req_green and
//   req_blue into entry req_entry_index, unless that is the fixed transparent
//   last entry or beyond, and answers with the packed word alpha, blue, green,
//   red. A query item (req_command = 1) expands the three 5-bit fields of
//   req_color15 as field*8+4 and answers with the index of the entry at the
//   least squared distance; on a tie the lowest index wins.
//   Each item gives exactly one result, shown for one cycle with rsp_strobe.
//   The receiver cannot stall, and none is needed: results are registered.
// Timing:
//   A load answers in the next cycle and busy stays low, so loads may follow
//   in every cycle. A query reads the palette memory one entry per cycle,
//   then waits for the read, square and compare stages to drain; its result
//   strobes in the cycle in which busy falls, and the next item may be
//   accepted in that same cycle.
// Reset:
//   Reset clears the per-entry valid bits at once, so every entry reads as
//   black; no clearing pass is needed and an item may be accepted right away.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rgb555_nearest_palette_index import rgbnpi_pkg::*; #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic        req_command,
   input  wire logic [7:0]  req_entry_index,
   input  wire logic [7:0]  req_red,
   input  wire logic [7:0]  req_green,
   input  wire logic [7:0]  req_blue,
   input  wire logic [14:0] req_color15,
   output      logic        rsp_strobe,
   output      logic [31:0] rsp_packed_word,
   output      logic [7:0]  rsp_nearest_index
);

   // Address width of the palette; PALETTE_ENTRIES ranges from 2 to 256.
   localparam int IDX_W = $clog2(PALETTE_ENTRIES);

   ctrl_cmd_type     cmd;
   dp_status_type    status;
   logic [IDX_W-1:0] rd_addr;

   // The controller steps the read address; the datapath does all the math.
   rgbnpi_ctrl #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES),
      .IDX_W           (IDX_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .busy        (busy),
      .cmd         (cmd),
      .rd_addr     (rd_addr),
      .status      (status)
   );

   rgbnpi_datapath #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES),
      .IDX_W           (IDX_W)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .rd_addr           (rd_addr),
      .status            (status),
      .req_entry_index   (req_entry_index),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_color15       (req_color15),
      .rsp_strobe        (rsp_strobe),
      .rsp_packed_word   (rsp_packed_word),
      .rsp_nearest_index (rsp_nearest_index)
   );

   // An accepted query keeps the block busy for its search.
   `ASSERT_NEXT(a_query_busy, start && !busy && req_command == CMD_QUERY, busy, "query did not start a search")

   // An accepted load is answered in the next cycle with an opaque packed word.
   `ASSERT_NEXT(a_load_answer, start && !busy && req_command == CMD_LOAD, rsp_strobe && rsp_packed_word[31:24] == ALPHA_OPAQUE, "load was not answered")

   // A result never carries both a packed word and a nonzero index.
   `ASSERT_SAME(a_rsp_exclusive, rsp_strobe, rsp_packed_word == 32'd0 || rsp_nearest_index == 8'd0, "result mixes load and query fields")

   // A query answer always names an entry that exists.
   `ASSERT_SAME(a_index_range, rsp_strobe, 9'(rsp_nearest_index) < 9'(PALETTE_ENTRIES), "nearest index out of range")

endmodule

`default_nettype wire

### hdl/rgbnpi_ctrl.sv
// ---------------------------------------------------------------------------
// rgbnpi_ctrl
// Controller: accepts items, steps the palette read address during a query
// and waits for the search pipeline to drain before the answer is issued.
// ---------------------------------------------------------------------------
`default_nettype none

module rgbnpi_ctrl import rgbnpi_pkg::*; #(
   parameter int PALETTE_ENTRIES = 256,
   parameter int IDX_W           = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             req_command,
   output      logic             busy,
   output      ctrl_cmd_type     cmd,
   output      logic [IDX_W-1:0] rd_addr,
   input  wire dp_status_type    status
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_DRAIN  = 3'b100
   } state_type;

   localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(PALETTE_ENTRIES - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] addr_ff, addr_in;

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_command == CMD_QUERY) begin
                  cmd.query_start = 1'b1;
                  addr_in         = '0;
                  state_in        = ST_SEARCH;
               end else begin
                  cmd.load_wr = 1'b1;
               end
            end
         end
         ST_SEARCH: begin
            cmd.rd_en = 1'b1;
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   assign busy    = (state_ff != ST_IDLE);
   assign rd_addr = addr_ff;

endmodule

`default_nettype wire

### hdl/rgbnpi_datapath.sv
// ---------------------------------------------------------------------------
// rgbnpi_datapath
// Palette memory with per-entry valid bits, the distance pipeline and the
// best-match tracker, plus the registered result outputs.
// ---------------------------------------------------------------------------
`default_nettype none

module rgbnpi_datapath import rgbnpi_pkg::*; #(
   parameter int PALETTE_ENTRIES = 256,
   parameter int IDX_W           = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ctrl_cmd_type     cmd,
   input  wire logic [IDX_W-1:0] rd_addr,
   output      dp_status_type    status,
   input  wire logic [7:0]       req_entry_index,
   input  wire logic [7:0]       req_red,
   input  wire logic [7:0]       req_green,
   input  wire logic [7:0]       req_blue,
   input  wire logic [14:0]      req_color15,
   output      logic             rsp_strobe,
   output      logic [31:0]      rsp_packed_word,
   output      logic [7:0]       rsp_nearest_index
);

   localparam logic [8:0] LAST_ENTRY = 9'(PALETTE_ENTRIES - 1);

   function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

   logic [23:0]                palette_mem [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] entry_vld_ff;

   logic             wr_ok;
   logic [IDX_W-1:0] wr_addr;

   logic [14:0]       color_ff;
   logic [23:0]       rd_data_ff;
   logic              s1_vld_ff, s1_hit_ff;
   logic [IDX_W-1:0]  s1_idx_ff;
   logic [15:0]       sq_r_ff, sq_g_ff, sq_b_ff;
   logic              s2_vld_ff;
   logic [IDX_W-1:0]  s2_idx_ff;
   logic [DIST_W-1:0] best_dist_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic              rsp_strobe_ff;
   logic [31:0]       rsp_packed_ff;
   logic [7:0]        rsp_index_ff;

   logic [23:0]       entry;
   logic [7:0]        q_red, q_green, q_blue;
   logic [7:0]        d_red, d_green, d_blue;
   logic [DIST_W-1:0] sum_dist;

   // The transparent entry and anything beyond it are never written.
   assign wr_ok   = ({1'b0, req_entry_index} < LAST_ENTRY);
   assign wr_addr = req_entry_index[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_wr && wr_ok) begin
         palette_mem[wr_addr] <= {req_blue, req_green, req_red};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= palette_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_vld_ff <= '0;
      end else if (cmd.load_wr && wr_ok) begin
         entry_vld_ff[wr_addr] <= 1'b1;
      end
   end

   // Stage 2: unwritten entries read as black; square the channel differences.
   assign entry   = s1_hit_ff ? rd_data_ff : '0;
   assign q_red   = {color_ff[4:0],   EXPAND_LOW_BITS};
   assign q_green = {color_ff[9:5],   EXPAND_LOW_BITS};
   assign q_blue  = {color_ff[14:10], EXPAND_LOW_BITS};
   assign d_red   = abs_diff(q_red,   entry[7:0]);
   assign d_green = abs_diff(q_green, entry[15:8]);
   assign d_blue  = abs_diff(q_blue,  entry[23:16]);

   // Stage 3: sum and compare; only a strictly smaller distance wins.
   assign sum_dist = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_vld_ff     <= cmd.rd_en;
         s2_vld_ff     <= s1_vld_ff;
         rsp_strobe_ff <= cmd.load_wr | cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.query_start) begin
         color_ff <= req_color15;
      end
      s1_hit_ff <= entry_vld_ff[rd_addr];
      s1_idx_ff <= rd_addr;
      sq_r_ff   <= 16'(d_red)   * 16'(d_red);
      sq_g_ff   <= 16'(d_green) * 16'(d_green);
      sq_b_ff   <= 16'(d_blue)  * 16'(d_blue);
      s2_idx_ff <= s1_idx_ff;
      if (cmd.query_start) begin
         best_dist_ff <= '1;
         best_idx_ff  <= '0;
      end else if (s2_vld_ff && (sum_dist < best_dist_ff)) begin
         best_dist_ff <= sum_dist;
         best_idx_ff  <= s2_idx_ff;
      end
      if (cmd.load_wr) begin
         rsp_packed_ff <= {ALPHA_OPAQUE, req_blue, req_green, req_red};
         rsp_index_ff  <= '0;
      end else if (cmd.finish) begin
         rsp_packed_ff <= '0;
         rsp_index_ff  <= 8'(best_idx_ff);
      end
   end

   assign status.pipe_busy  = s1_vld_ff | s2_vld_ff;
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_packed_word   = rsp_packed_ff;
   assign rsp_nearest_index = rsp_index_ff;

endmodule

`default_nettype wire
